FILE: rtl/fhp_pkg.sv
// Shared types and constants for the fifteen-tap high-pass filter.
package fhp_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int TAPS      = 15;
    localparam int HIST      = TAPS - 1;
    localparam int CENTER    = TAPS / 2;
    localparam int NUM_COEF  = 8;
    localparam int COEF_IDX_W = 3;
    localparam int CFG_IDX_W = 4;
    localparam int ADDR_W    = 4;
    localparam int TAP_W     = 4;

    // Power-on coefficients, Q1.15, outer pair first, center tap last
    localparam int COEF_RESET [NUM_COEF] = '{
        -1474, -285, -306, -325, -340, -352, -357, 32409
    };

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [ADDR_W-1:0]          t_addr;
    typedef logic [TAP_W-1:0]           t_tap;

    typedef struct packed {
        t_sample sample_in;
    } t_in;

    typedef struct packed {
        t_sample sample_out;
        logic    clipped;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND
    } t_state;

    // Controls from the sequencer to the datapath
    typedef struct packed {
        logic x_load;
        logic acc_clr;
        logic mul_en;
        logic use_x;
        logic opnd_vld;
        logic out_load;
    } t_mac_ctl;

    // Delay-line memory port controls
    typedef struct packed {
        logic  re;
        t_addr raddr;
        logic  we;
        t_addr waddr;
    } t_ram_ctl;

endpackage

FILE: rtl/fhp_ifs.sv
// Valid/ready stream and configuration write interfaces of the filter.
interface fhp_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fhp_cfg_if #(parameter int DATA_W = 16);
    logic                           valid;
    logic                           ready;
    logic [fhp_pkg::CFG_IDX_W-1:0]  index;
    logic [DATA_W-1:0]              data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/fhp_ram.sv
// Generic simple dual-port RAM with registered read.
module fhp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 14
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/fhp_coef_bank.sv
// Coefficient registers, config write port and per-tap coefficient select.
module fhp_coef_bank #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fhp_cfg_if.sink                       i_cfg,
    input  fhp_pkg::t_tap                 i_tap,
    output logic signed [COEF_WIDTH-1:0]  o_coef
);
    import fhp_pkg::*;

    logic signed [COEF_WIDTH-1:0] r_coef [NUM_COEF];
    logic [COEF_IDX_W-1:0]        w_sel;
    logic                         w_wr;

    // Writes are always taken; indexes past the list are dropped
    assign i_cfg.ready = 1'b1;
    assign w_wr = i_cfg.valid && (i_cfg.index < CFG_IDX_W'(NUM_COEF));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                r_coef[i] <= COEF_WIDTH'(COEF_RESET[i]);
            end
        end else if (w_wr) begin
            r_coef[i_cfg.index[COEF_IDX_W-1:0]] <= i_cfg.data[COEF_WIDTH-1:0];
        end
    end

    // Fold tap number onto its symmetric pair; center has its own register
    always_comb begin
        if (i_tap == TAP_W'(CENTER)) begin
            w_sel = COEF_IDX_W'(NUM_COEF - 1);
        end else if (i_tap > TAP_W'(CENTER)) begin
            w_sel = COEF_IDX_W'(TAP_W'(HIST) - i_tap);
        end else begin
            w_sel = i_tap[COEF_IDX_W-1:0];
        end
    end

    assign o_coef = r_coef[w_sel];
endmodule

FILE: rtl/fhp_mac.sv
// Shared multiply-accumulate datapath with rounding, saturation and output register.
module fhp_mac #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fhp_pkg::t_mac_ctl             i_ctl,
    input  fhp_pkg::t_sample              i_sample,
    input  fhp_pkg::t_sample              i_rdata,
    input  logic signed [COEF_WIDTH-1:0]  i_coef,
    output fhp_pkg::t_sample              o_x,
    output fhp_pkg::t_out                 o_res
);
    import fhp_pkg::*;

    localparam int PROD_W = SAMPLE_W + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + 4;
    localparam int FRAC   = COEF_WIDTH - 1;
    localparam int Q_W    = ACC_W - FRAC;
    localparam logic [ACC_W-1:0] BIAS = {{(ACC_W - FRAC){1'b0}}, {FRAC{1'b1}}};

    t_sample                   r_x;
    t_sample                   w_opnd;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_prod_v;
    logic signed [ACC_W-1:0]   r_acc;
    logic [ACC_W-1:0]          w_sum;
    logic [Q_W-1:0]            w_q;
    logic                      w_fits;
    t_out                      w_res;
    t_out                      r_res;

    // Current sample, tap 0 and the value written back to the delay line
    always_ff @(posedge i_clk) begin
        if (i_ctl.x_load) begin
            r_x <= i_sample;
        end
    end

    // Multiply stage; entries never written read as zero
    always_comb begin
        if (i_ctl.use_x) begin
            w_opnd = r_x;
        end else if (i_ctl.opnd_vld) begin
            w_opnd = i_rdata;
        end else begin
            w_opnd = '0;
        end
    end

    assign w_prod = w_opnd * i_coef;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= w_prod;
        end
    end

    // Accumulate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= i_ctl.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Shift toward zero: bias negatives before the arithmetic shift
    assign w_sum  = r_acc + (r_acc[ACC_W-1] ? BIAS : '0);
    assign w_q    = w_sum[ACC_W-1:FRAC];
    assign w_fits = (&w_q[Q_W-1:SAMPLE_W-1]) || !(|w_q[Q_W-1:SAMPLE_W-1]);

    // Saturate to int16
    always_comb begin
        w_res.clipped = !w_fits;
        if (w_fits) begin
            w_res.sample_out = w_q[SAMPLE_W-1:0];
        end else if (w_q[Q_W-1]) begin
            w_res.sample_out = {1'b1, {(SAMPLE_W - 1){1'b0}}};
        end else begin
            w_res.sample_out = {1'b0, {(SAMPLE_W - 1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_res <= w_res;
        end
    end

    assign o_x   = r_x;
    assign o_res = r_res;
endmodule

FILE: rtl/fhp_ctrl.sv
// Sequencer: tap counter, delay-line ring addressing, valid bits and output handshake.
module fhp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output fhp_pkg::t_mac_ctl   o_ctl,
    output fhp_pkg::t_tap       o_tap,
    output fhp_pkg::t_ram_ctl   o_ram
);
    import fhp_pkg::*;

    t_state          r_state;
    t_state          n_state;
    t_tap            r_cnt;
    t_addr           r_head;
    logic [HIST-1:0] r_vld;
    logic            r_opnd_vld;
    logic            r_out_valid;
    logic            w_accept;
    logic            w_last;
    logic            w_out_load;

    // Address of delay entry tap-1 (tap 1 is the newest stored sample)
    function automatic t_addr ring_addr(t_addr head, t_tap tap);
        logic [ADDR_W:0] sum;
        if (head >= tap) begin
            sum = {1'b0, head} - {1'b0, tap};
        end else begin
            sum = {1'b0, head} + (ADDR_W + 1)'(HIST) - {1'b0, tap};
        end
        return sum[ADDR_W-1:0];
    endfunction

    assign w_accept   = (r_state == ST_IDLE) && i_in_valid;
    assign w_last     = (r_cnt == TAP_W'(TAPS - 1));
    assign w_out_load = (r_state == ST_ROUND) && (!r_out_valid || i_out_ready);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_MAC;
            ST_MAC:   if (w_last) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_ROUND;
            ST_ROUND: if (w_out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready      = (r_state == ST_IDLE);
        o_ctl.x_load    = w_accept;
        o_ctl.acc_clr   = w_accept;
        o_ctl.mul_en    = (r_state == ST_MAC);
        o_ctl.use_x     = (r_cnt == '0);
        o_ctl.opnd_vld  = r_opnd_vld;
        o_ctl.out_load  = w_out_load;
        o_tap           = r_cnt;
        o_ram.re        = (r_state == ST_MAC) && !w_last;
        o_ram.raddr     = ring_addr(r_head, r_cnt + 1'b1);
        o_ram.we        = (r_state == ST_MAC) && w_last;
        o_ram.waddr     = r_head;
        o_out_valid     = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Tap counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_accept) begin
            r_cnt <= '0;
        end else if (r_state == ST_MAC && !w_last) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Ring head and per-entry valid bits; the write-back replaces the oldest entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_vld      <= '0;
            r_opnd_vld <= 1'b0;
        end else begin
            r_opnd_vld <= o_ram.re && r_vld[o_ram.raddr];
            if (o_ram.we) begin
                r_vld[r_head] <= 1'b1;
                r_head <= (r_head == ADDR_W'(HIST - 1)) ? '0 : r_head + 1'b1;
            end
        end
    end

    // Output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_MAC) && (r_cnt == '0))
        else $error("accepted beat did not start the tap sweep");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> (r_cnt <= TAP_W'(TAPS - 1)))
        else $error("tap counter past last tap");

    a_head_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.we |=> (r_head == (($past(r_head) == ADDR_W'(HIST - 1)) ? '0
                                  : $past(r_head) + 1'b1)))
        else $error("ring head did not advance after write-back");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken output beat");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= ADDR_W'(HIST - 1))
        else $error("ring head outside delay line");
endmodule

FILE: rtl/fir_highpass_int16_saturating.sv
// Fifteen-tap symmetric high-pass FIR filter on signed 16-bit samples.
//
// Channels: i_in takes one sample per beat (valid/ready); o_out returns one
// filtered sample with a clip flag per input beat, in order. i_cfg writes the
// eight Q1.(COEF_WIDTH-1) coefficient registers (index 0..6 tap pairs, 7 the
// center tap); other indexes are ignored. Its DATA_W must equal COEF_WIDTH.
// Write coefficients only while no sample is in flight.
//
// Sequence: a sample goes from acceptance to its output beat through an accept
// step, fifteen passes of the single shared multiplier (one tap per cycle,
// delay line read from a one-port-read ring RAM), an accumulate drain and a
// round/saturate step. The next sample is accepted in the cycle after its
// predecessor's result is registered, so a new sample is not taken before
// the last one is through.
//
// Reset: coefficients take their default high-pass values and the delay line
// reads as zero (per-entry valid bits, no clearing pass). If the receiver
// stalls, the result waits in the output register and one further sample may
// be accepted and computed; it then holds until the output frees.
module fir_highpass_int16_saturating #(
    parameter int COEF_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fhp_stream_if.sink  i_in,
    fhp_stream_if.source o_out,
    fhp_cfg_if.sink     i_cfg
);
    import fhp_pkg::*;

    t_mac_ctl                     w_ctl;
    t_ram_ctl                     w_ram;
    t_tap                         w_tap;
    t_sample                      w_x;
    t_sample                      w_rdata;
    t_in                          w_in;
    t_out                         w_res;
    logic signed [COEF_WIDTH-1:0] w_coef;
    logic                         w_in_ready;
    logic                         w_out_valid;

    assign w_in        = i_in.data;
    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_res;

    fhp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_ctl       (w_ctl),
        .o_tap       (w_tap),
        .o_ram       (w_ram)
    );

    fhp_coef_bank #(.COEF_WIDTH(COEF_WIDTH)) u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_tap   (w_tap),
        .o_coef  (w_coef)
    );

    // Delay line ring
    fhp_ram #(.WIDTH(SAMPLE_W), .DEPTH(HIST)) u_delay (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_x),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    fhp_mac #(.COEF_WIDTH(COEF_WIDTH)) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (w_in.sample_in),
        .i_rdata  (w_rdata),
        .i_coef   (w_coef),
        .o_x      (w_x),
        .o_res    (w_res)
    );
endmodule
